### hdl/sida_pkg.sv
// ----------------------------------------------------------------------------
// sida_pkg
// Shared constants for the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sida_pkg;

    localparam int VALUE_WIDTH = 32;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // decimal digits needed for the largest magnitude, 2^(w-1)
    function automatic int dec_digits(input int w);
        logic [63:0] x;
        int          n;
        begin
            x = 64'd1 << (w - 1);
            n = 0;
            while (x != 64'd0)
            begin
                x = x / 10;
                n = n + 1;
            end
            return n;
        end
    endfunction

    localparam int NUM_DIGITS = dec_digits(VALUE_WIDTH);
    localparam int BCD_WIDTH  = NUM_DIGITS * 4;
    localparam int BIT_CNT_W  = $clog2(VALUE_WIDTH);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

endpackage

`default_nettype wire

### hdl/sida_if.sv
// ----------------------------------------------------------------------------
// sida_if
// Valid/ready channels for the integer input and the character output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sida_in_if
    import sida_pkg::*;
;
    logic                           valid;
    logic                           ready;
    logic signed [VALUE_WIDTH-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sida_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

`default_nettype wire

### hdl/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed integer to its decimal ASCII text, most significant first.
// ----------------------------------------------------------------------------
// sequence: shift-add-3 conversion of the magnitude, then leading zero digits
// are skipped, then the sign if negative and the digits are offered in turn
// input: a new value is accepted only in idle, after the last character is taken,
// as the single shared shift-add-3 bcd unit and serial character output are reused
// reset: rst_n asynchronous active low, returns the sequencer to idle
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii
    import sida_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    sida_in_if.sink          value_ch,
    sida_out_if.source       text_ch
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_SKIP = 5'b00100,
        ST_SIGN = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [BCD_WIDTH-1:0]   bcd_reg, bcd_next;
    logic                   neg_reg, neg_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]   dig_cnt_reg, dig_cnt_next;

    logic [BCD_WIDTH-1:0]   bcd_adj;
    logic [3:0]             top_digit;
    logic                   in_fire;
    logic                   out_fire;
    logic                   last_digit;

    assign top_digit  = bcd_reg[BCD_WIDTH-1 -: 4];
    assign last_digit = (dig_cnt_reg == DIG_CNT_W'(1));
    assign in_fire    = value_ch.valid && value_ch.ready;
    assign out_fire   = text_ch.valid && text_ch.ready;

    assign value_ch.ready    = (state_reg == ST_IDLE);
    assign text_ch.valid     = (state_reg == ST_SIGN) || (state_reg == ST_EMIT);
    assign text_ch.text_char = (state_reg == ST_SIGN) ? CHAR_MINUS
                                                      : CHAR_ZERO + {4'b0000, top_digit};
    assign text_ch.last_char = (state_reg == ST_EMIT) && last_digit;

    // add 3 to every bcd digit of 5 or more
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        neg_next     = neg_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    neg_next     = value_ch.value[VALUE_WIDTH-1];
                    mag_next     = value_ch.value[VALUE_WIDTH-1]
                                 ? (~value_ch.value) + VALUE_WIDTH'(1)
                                 : value_ch.value;
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    dig_cnt_next = DIG_CNT_W'(NUM_DIGITS);
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next     = {bcd_adj[BCD_WIDTH-2:0], mag_reg[VALUE_WIDTH-1]};
                mag_next     = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_CNT_W'(VALUE_WIDTH - 1))
                    state_next = ST_SKIP;
            end
            ST_SKIP:
            begin
                if ((top_digit == 4'd0) && !last_digit)
                begin
                    bcd_next     = {bcd_reg[BCD_WIDTH-5:0], 4'b0000};
                    dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
                end
                else
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
            end
            ST_SIGN:
            begin
                if (out_fire)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_fire)
                begin
                    if (last_digit)
                        state_next = ST_IDLE;
                    else
                    begin
                        bcd_next     = {bcd_reg[BCD_WIDTH-5:0], 4'b0000};
                        dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    // input and output never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        !(value_ch.ready && text_ch.valid))
        else $error("input ready while a word is offered");

    // a new value starts conversion, no word follows at once
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !text_ch.valid && !value_ch.ready)
        else $error("conversion did not start after accept");

    // the final word is always a digit
    assert property (@(posedge clk) disable iff (!rst_n)
        (text_ch.valid && text_ch.last_char) |->
        (text_ch.text_char >= CHAR_ZERO && text_ch.text_char <= CHAR_ZERO + 8'd9))
        else $error("last word is not a digit");

    // a sign word is always followed by a digit word
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && text_ch.text_char == CHAR_MINUS) |=>
        (text_ch.valid && text_ch.text_char != CHAR_MINUS))
        else $error("sign not followed by a digit");

endmodule

`default_nettype wire
